// ===== hdl/tsse_pkg.sv =====
// Package for the task scheduler / semaphore engine.
// Task state codes, request modes and status codes. No dependencies.
package tsse_pkg;

    typedef enum logic [2:0] {
        ST_INVALID = 3'd0,
        ST_UNRUN   = 3'd1,
        ST_READY   = 3'd2,
        ST_DELAYED = 3'd3,
        ST_BLOCKED = 3'd4
    } t_task_st;

    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_TICK     = 3'd1;
    localparam logic [2:0] MODE_SCHEDULE = 3'd2;
    localparam logic [2:0] MODE_YIELD    = 3'd3;
    localparam logic [2:0] MODE_SLEEP    = 3'd4;
    localparam logic [2:0] MODE_WAIT     = 3'd5;
    localparam logic [2:0] MODE_POST     = 3'd6;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_SEM = 2'd1;
    localparam logic [1:0] STAT_Q_FULL  = 2'd2;
    localparam logic [1:0] STAT_NO_RUN  = 2'd3;

    localparam logic [2:0] REG_MASK = 3'd0;
    localparam logic [2:0] REG_NSEM = 3'd1;

    localparam int INIT_REGS = 5;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } t_fsm;

    // Command to every task cell for one cycle.
    typedef struct packed {
        logic load;      // start: take mask bit
        logic tick;      // count down if delayed
        logic set_ready; // addressed cell becomes ready
        logic set_delay; // addressed cell becomes delayed
        logic set_block; // addressed cell becomes blocked
        logic wake;      // addressed cell: blocked -> ready
        logic rotate;    // scan ring shifts one place
    } t_cell_cmd;

endpackage

// ===== hdl/tsse_cell.sv =====
// One task slot: state and tick count, plus one stage of the scan ring.
// Depends on tsse_pkg.
module tsse_cell
    import tsse_pkg::*;
#(
    parameter int TICK_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_cmd             i_cmd,
    input  logic                  i_sel,
    input  logic                  i_mask_bit,
    input  logic [TICK_WIDTH-1:0] i_ticks,
    input  logic                  i_ring,
    output logic                  o_ring,
    output t_task_st              o_state
);
    t_task_st              r_state, n_state;
    logic [TICK_WIDTH-1:0] r_ticks, n_ticks;
    logic                  r_ring;

    always_comb begin
        n_state = r_state;
        n_ticks = r_ticks;
        if (i_cmd.load) begin
            n_state = i_mask_bit ? ST_UNRUN : ST_INVALID;
            n_ticks = '0;
        end else if (i_cmd.tick && r_state == ST_DELAYED) begin
            if (r_ticks <= TICK_WIDTH'(1)) begin
                n_ticks = '0;
                n_state = ST_READY;
            end else begin
                n_ticks = r_ticks - TICK_WIDTH'(1);
            end
        end else if (i_sel) begin
            if (i_cmd.set_ready) n_state = ST_READY;
            else if (i_cmd.set_delay) begin
                n_state = ST_DELAYED;
                n_ticks = i_ticks;
            end else if (i_cmd.set_block) n_state = ST_BLOCKED;
            else if (i_cmd.wake && r_state == ST_BLOCKED) n_state = ST_READY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INVALID;
            r_ticks <= '0;
            r_ring  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ticks <= n_ticks;
            // ring holds runnable flags; rotates one slot per scan cycle
            r_ring  <= i_cmd.rotate ? i_ring
                     : (n_state == ST_READY || n_state == ST_UNRUN);
        end
    end

    assign o_ring  = r_ring;
    assign o_state = r_state;
endmodule

// ===== hdl/tsse_sem.sv =====
// Counting semaphores with per-semaphore wait FIFOs.
// Depends on tsse_pkg.
module tsse_sem
    import tsse_pkg::*;
#(
    parameter int NUM_SEMS    = 5,
    parameter int QUEUE_DEPTH = 5,
    parameter int TW          = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [2:0]             i_nsem,
    input  logic [INIT_REGS*8-1:0] i_init,
    input  logic                   i_dec,
    input  logic                   i_push,
    input  logic                   i_pop,
    input  logic                   i_inc,
    input  logic [2:0]             i_idx,
    input  logic [TW-1:0]          i_task,
    output logic                   o_cnt_nz,
    output logic                   o_q_full,
    output logic                   o_q_nz,
    output logic [TW-1:0]          o_head
);
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int QI = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

    logic [15:0]   r_cnt [NUM_SEMS];
    logic [QW-1:0] r_len [NUM_SEMS];
    logic [TW-1:0] r_q   [NUM_SEMS][QUEUE_DEPTH];
    logic [SW-1:0] w_s;

    assign w_s      = SW'(i_idx);
    assign o_cnt_nz = r_cnt[w_s] != 16'd0;
    assign o_q_full = r_len[w_s] >= QW'(QUEUE_DEPTH);
    assign o_q_nz   = r_len[w_s] != '0;
    assign o_head   = r_q[w_s][0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SEMS; s++) begin
                r_cnt[s] <= '0;
                r_len[s] <= '0;
            end
        end else if (i_load) begin
            for (int s = 0; s < NUM_SEMS; s++) begin
                r_len[s] <= '0;
                if (s < INIT_REGS && 3'(s) < i_nsem)
                    r_cnt[s] <= {8'd0, i_init[(s % INIT_REGS)*8 +: 8]};
                else
                    r_cnt[s] <= '0;
            end
        end else begin
            if (i_dec) r_cnt[w_s] <= r_cnt[w_s] - 16'd1;
            if (i_inc && r_cnt[w_s] != 16'hFFFF) r_cnt[w_s] <= r_cnt[w_s] + 16'd1;
            // push only when not full, so the length is a valid slot
            if (i_push) begin
                r_q[w_s][QI'(r_len[w_s])] <= i_task;
                r_len[w_s] <= r_len[w_s] + QW'(1);
            end
            if (i_pop) begin
                for (int k = 0; k + 1 < QUEUE_DEPTH; k++) r_q[w_s][k] <= r_q[w_s][k+1];
                r_len[w_s] <= r_len[w_s] - QW'(1);
            end
        end
    end
endmodule

// ===== hdl/task_scheduler_semaphore_engine.sv =====
// Top level of the task scheduler / semaphore engine: control FSM, task cells
// in a ring, semaphore unit. Depends on tsse_pkg, tsse_cell, tsse_sem.
//
//  channel  | ports                                   | accept
//  ---------+-----------------------------------------+--------------------
//  config   | i_cfg_we i_cfg_index i_cfg_data         | i_cfg_we
//  request  | start busy i_mode i_sleep_ticks i_sem.. | start && !busy
//  result   | o_valid o_running_task .. o_status      | o_valid (one cycle)
//
// Tick, yield, sleep, wait, post: the request passes from IDLE to DONE, where the result is formed and registered.
// Start and schedule: the runnable flags rotate through the cell ring one slot
// per cycle and the first hit after the pointer wins.
// busy covers the whole request; reset is synchronous, active low.
// Results cannot be stalled.
module task_scheduler_semaphore_engine
    import tsse_pkg::*;
#(
    parameter int NUM_TASKS   = 12,
    parameter int NUM_SEMS    = 5,
    parameter int QUEUE_DEPTH = 5,
    parameter int TICK_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_sleep_ticks,
    input  logic [2:0]  i_sem_index,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    output logic        o_valid,
    output logic [3:0]  o_running_task,
    output logic        o_first_run,
    output logic        o_switch_request,
    output logic [1:0]  o_status
);
    localparam int TW = 4;
    localparam int CW = $clog2(NUM_TASKS + 1);

    logic [11:0]            r_mask;
    logic [2:0]             r_nsem;
    logic [INIT_REGS*8-1:0] r_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_nsem <= '0;
            r_init <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MASK) r_mask <= i_cfg_data;
            else if (i_cfg_index == REG_NSEM) r_nsem <= i_cfg_data[2:0];
            else if (i_cfg_index <= 3'd6)
                r_init[(32'(i_cfg_index) - 2) * 8 +: 8] <= i_cfg_data[7:0];
        end
    end

    t_fsm                  r_fsm, n_fsm;
    logic [2:0]            r_mode;
    logic [TICK_WIDTH-1:0] r_ticks;
    logic [2:0]            r_si;
    logic [TW-1:0]         r_cur, r_ptr, r_pos, n_cur, n_ptr, n_pos;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_found, n_found;
    logic                  n_valid, n_first, n_sw;
    logic [1:0]            n_stat;
    logic                  r_valid, r_first, r_sw;
    logic [1:0]            r_stat;

    t_cell_cmd             w_cmd;
    logic [NUM_TASKS-1:0]  w_sel, w_ring_in, w_ring_out;
    t_task_st              w_st [NUM_TASKS];
    logic [TW-1:0]         w_tgt, w_head;
    logic                  w_cnt_nz, w_q_full, w_q_nz;
    logic                  w_dec, w_push, w_pop, w_inc, w_load;
    logic                  w_caller_ok, w_si_ok;
    logic [2:0]            w_nsem;

    assign w_nsem      = (32'(r_nsem) < NUM_SEMS) ? r_nsem : 3'(NUM_SEMS);
    assign w_caller_ok = w_st[r_cur] == ST_READY;
    assign w_si_ok     = r_si < w_nsem;

    for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
        assign w_sel[g]     = w_tgt == TW'(g);
        assign w_ring_in[g] = w_ring_out[(g + 1) % NUM_TASKS];
        tsse_cell #(.TICK_WIDTH(TICK_WIDTH)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_sel     (w_sel[g]),
            .i_mask_bit((g < 12) ? r_mask[g % 12] : 1'b0),
            .i_ticks   (r_ticks),
            .i_ring    (w_ring_in[g]),
            .o_ring    (w_ring_out[g]),
            .o_state   (w_st[g])
        );
    end

    tsse_sem #(.NUM_SEMS(NUM_SEMS), .QUEUE_DEPTH(QUEUE_DEPTH), .TW(TW)) u_sem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_nsem  (r_nsem),
        .i_init  (r_init),
        .i_dec   (w_dec),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .i_inc   (w_inc),
        .i_idx   (r_si),
        .i_task  (r_cur),
        .o_cnt_nz(w_cnt_nz),
        .o_q_full(w_q_full),
        .o_q_nz  (w_q_nz),
        .o_head  (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= FSM_IDLE;
            r_cur   <= '0;
            r_ptr   <= TW'(NUM_TASKS - 1);
            r_pos   <= '0;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
            r_first <= 1'b0;
            r_sw    <= 1'b0;
            r_stat  <= STAT_OK;
        end else begin
            r_fsm   <= n_fsm;
            r_cur   <= n_cur;
            r_ptr   <= n_ptr;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_found <= n_found;
            r_valid <= n_valid;
            r_first <= n_first;
            r_sw    <= n_sw;
            r_stat  <= n_stat;
        end
        if (start && !busy) begin
            r_mode  <= i_mode;
            r_ticks <= i_sleep_ticks[TICK_WIDTH-1:0];
            r_si    <= i_sem_index;
        end
    end

    // ring slot currently at cell 0 index position
    always_comb begin
        n_fsm   = r_fsm;
        n_cur   = r_cur;
        n_ptr   = r_ptr;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_found = r_found;
        n_valid = 1'b0;
        n_first = 1'b0;
        n_sw    = 1'b0;
        n_stat  = STAT_OK;
        w_cmd   = '0;
        w_tgt   = r_cur;
        w_load  = 1'b0;
        w_dec   = 1'b0;
        w_push  = 1'b0;
        w_pop   = 1'b0;
        w_inc   = 1'b0;
        unique case (r_fsm)
            FSM_IDLE: begin
                if (start) n_fsm = FSM_DONE;
            end
            FSM_DONE: begin
                n_fsm = FSM_IDLE;
                unique case (r_mode)
                    MODE_START, MODE_SCHEDULE: begin
                        if (r_mode == MODE_START) begin
                            w_cmd.load = 1'b1;
                            w_load     = 1'b1;
                            n_ptr      = TW'(NUM_TASKS - 1);
                        end
                        // ring loads flags this cycle; scan starts next
                        n_pos   = '0;
                        n_cnt   = '0;
                        n_found = 1'b0;
                        n_fsm   = FSM_SCAN;
                    end
                    MODE_TICK: begin
                        w_cmd.tick = 1'b1;
                        n_valid    = 1'b1;
                    end
                    MODE_YIELD: begin
                        n_valid = 1'b1;
                        if (w_caller_ok) n_sw = 1'b1;
                        else n_stat = STAT_NO_RUN;
                    end
                    MODE_SLEEP: begin
                        n_valid = 1'b1;
                        if (w_caller_ok) begin
                            w_cmd.set_delay = 1'b1;
                            n_sw = 1'b1;
                        end else n_stat = STAT_NO_RUN;
                    end
                    MODE_WAIT: begin
                        n_valid = 1'b1;
                        if (!w_caller_ok) n_stat = STAT_NO_RUN;
                        else if (!w_si_ok) n_stat = STAT_BAD_SEM;
                        else if (w_cnt_nz) w_dec = 1'b1;
                        else if (w_q_full) n_stat = STAT_Q_FULL;
                        else begin
                            w_push = 1'b1;
                            w_cmd.set_block = 1'b1;
                            n_sw = 1'b1;
                        end
                    end
                    MODE_POST: begin
                        n_valid = 1'b1;
                        if (!w_si_ok) n_stat = STAT_BAD_SEM;
                        else if (w_q_nz) begin
                            w_pop = 1'b1;
                            w_cmd.wake = 1'b1;
                            w_tgt = w_head;
                        end else w_inc = 1'b1;
                    end
                    default: n_valid = 1'b1;
                endcase
            end
            FSM_SCAN: begin
                // ring rotates so that cell 0 shows slot r_pos each cycle
                w_cmd.rotate = 1'b1;
                n_pos = (r_pos == TW'(NUM_TASKS - 1)) ? '0 : r_pos + TW'(1);
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(NUM_TASKS)) begin
                    w_cmd.rotate = 1'b0;
                    n_fsm   = FSM_IDLE;
                    n_valid = 1'b1;
                    if (r_found) begin
                        w_tgt = r_cur;
                        w_cmd.set_ready = 1'b1;
                        n_first = w_st[r_cur] == ST_UNRUN;
                        n_sw = 1'b1;
                        n_ptr = r_cur;
                    end else n_stat = STAT_NO_RUN;
                end else if (w_ring_out[0]) begin
                    // pick the hit closest after the pointer
                    if (!r_found || (r_pos > r_ptr && (r_cur <= r_ptr || r_pos < r_cur))
                        || (r_pos <= r_ptr && r_cur <= r_ptr && r_pos < r_cur)) begin
                        n_found = 1'b1;
                        n_cur   = r_pos;
                    end
                end
            end
            default: n_fsm = FSM_IDLE;
        endcase
    end

    assign busy             = r_fsm != FSM_IDLE;
    assign o_valid          = r_valid;
    assign o_running_task   = r_cur;
    assign o_first_run      = r_first;
    assign o_switch_request = r_sw;
    assign o_status         = r_stat;
endmodule

// ===== hdl/tsse_checker.sv =====
// Port-level checker for the task scheduler / semaphore engine, with bind.
// Depends on tsse_pkg.
module tsse_checker
    import tsse_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic       o_first_run,
    input logic       o_switch_request,
    input logic [1:0] o_status
);
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("request not taken");
    a_one_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double result");
    a_first_sw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_first_run |-> o_switch_request) else $error("first w/o switch");
    a_err_nosw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_OK |-> !o_switch_request) else $error("switch on error");
    a_res_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
endmodule

bind task_scheduler_semaphore_engine tsse_checker u_tsse_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_first_run(o_first_run),
    .o_switch_request(o_switch_request), .o_status(o_status)
);
